[design/msd_pkg.sv]
package msd_pkg;

    localparam logic [7:0] DIT_BYTE   = 8'h69;
    localparam logic [7:0] DAH_BYTE   = 8'h61;
    localparam logic [7:0] GAP_BYTE   = 8'h20;
    localparam logic [7:0] CODE_START = 8'h01;
    localparam logic [7:0] NO_CHAR    = 8'h00;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] symbol_byte;
        logic       end_of_message;
    } sym_t;

    typedef struct packed {
        logic [7:0] decoded_char;
        logic       message_done;
        logic       overlong;
    } res_t;

    typedef struct packed {
        logic shift_en;
        logic shift_bit;
        logic emit;
        logic eom;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] lookup_code(input logic [7:0] code);
        logic [7:0] ch;
        unique case (code)
            8'h06: ch = 8'h61;
            8'h17: ch = 8'h62;
            8'h15: ch = 8'h63;
            8'h0B: ch = 8'h64;
            8'h03: ch = 8'h65;
            8'h1D: ch = 8'h66;
            8'h09: ch = 8'h67;
            8'h1F: ch = 8'h68;
            8'h07: ch = 8'h69;
            8'h18: ch = 8'h6A;
            8'h0A: ch = 8'h6B;
            8'h1B: ch = 8'h6C;
            8'h04: ch = 8'h6D;
            8'h05: ch = 8'h6E;
            8'h08: ch = 8'h6F;
            8'h19: ch = 8'h70;
            8'h12: ch = 8'h71;
            8'h0D: ch = 8'h72;
            8'h0F: ch = 8'h73;
            8'h02: ch = 8'h74;
            8'h0E: ch = 8'h75;
            8'h1E: ch = 8'h76;
            8'h0C: ch = 8'h77;
            8'h16: ch = 8'h78;
            8'h14: ch = 8'h79;
            8'h13: ch = 8'h7A;
            8'h30: ch = 8'h31;
            8'h38: ch = 8'h32;
            8'h3C: ch = 8'h33;
            8'h3E: ch = 8'h34;
            8'h3F: ch = 8'h35;
            8'h2F: ch = 8'h36;
            8'h27: ch = 8'h37;
            8'h23: ch = 8'h38;
            8'h21: ch = 8'h39;
            8'h20: ch = 8'h30;
            8'h6A: ch = 8'h2E;
            8'h73: ch = 8'h3F;
            8'h54: ch = 8'h21;
            8'h29: ch = 8'h28;
            8'h53: ch = 8'h29;
            8'h47: ch = 8'h3A;
            8'h2E: ch = 8'h3D;
            8'h5E: ch = 8'h2D;
            8'h6D: ch = 8'h22;
            8'h4C: ch = 8'h2C;
            8'h61: ch = 8'h27;
            8'h2D: ch = 8'h2F;
            8'h55: ch = 8'h3B;
            8'h72: ch = 8'h5F;
            8'h65: ch = 8'h40;
            8'hFF: ch = 8'h20;
            default: ch = NO_CHAR;
        endcase
        return ch;
    endfunction

endpackage

[design/msd_front.sv]
module msd_front (
    input  logic               sym_valid,
    output logic               sym_ready,
    input  msd_pkg::sym_t      sym,
    input  msd_pkg::q_status_t q_status,
    output logic               push,
    output msd_pkg::op_t       push_op
);

    logic is_dit;
    logic is_dah;
    logic is_gap;

    assign is_dit = (sym.symbol_byte == msd_pkg::DIT_BYTE);
    assign is_dah = (sym.symbol_byte == msd_pkg::DAH_BYTE);
    assign is_gap = (sym.symbol_byte == msd_pkg::GAP_BYTE);

    always_comb
    begin
        push_op.shift_en  = is_dit | is_dah;
        push_op.shift_bit = is_dit;
        push_op.emit      = is_gap | sym.end_of_message;
        push_op.eom       = sym.end_of_message;
    end

    // drop beats that change nothing
    assign sym_ready = !q_status.full;
    assign push      = sym_valid && sym_ready && (push_op.shift_en || push_op.emit);

endmodule

[design/msd_queue.sv]
module msd_queue #(
    parameter int DEPTH = msd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  msd_pkg::op_t               push_op,
    input  logic                       pop,
    output msd_pkg::op_t               pop_op,
    output msd_pkg::q_status_t         q_status,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    msd_pkg::op_t     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    assign pop_op         = mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == FULL_CNT);
    assign q_status.empty = (count_reg == '0);
    assign count          = count_reg;

endmodule

[design/msd_back.sv]
module msd_back (
    input  logic               clk,
    input  logic               rst_n,
    input  msd_pkg::q_status_t q_status,
    input  msd_pkg::op_t       pop_op,
    output logic               pop,
    output logic               res_valid,
    input  logic               res_ready,
    output msd_pkg::res_t      res
);

    logic [7:0]    code_shift_reg;
    logic [7:0]    code_shift_next;
    logic          overflow_seen_reg;
    logic          overflow_seen_next;
    logic          res_valid_reg;
    logic          res_valid_next;
    msd_pkg::res_t res_reg;
    msd_pkg::res_t res_next;
    logic [7:0]    code_new;
    logic          ovf_new;
    logic          out_free;

    assign out_free = !res_valid_reg || res_ready;
    assign pop      = !q_status.empty && (!pop_op.emit || out_free);

    always_comb
    begin
        code_new = code_shift_reg;
        ovf_new  = overflow_seen_reg;
        if (pop_op.shift_en)
        begin
            ovf_new  = overflow_seen_reg | code_shift_reg[7];
            code_new = {code_shift_reg[6:0], pop_op.shift_bit};
        end
    end

    always_comb
    begin
        code_shift_next    = code_shift_reg;
        overflow_seen_next = overflow_seen_reg;
        res_valid_next     = res_valid_reg && !res_ready;
        res_next           = res_reg;
        if (pop)
        begin
            code_shift_next    = code_new;
            overflow_seen_next = ovf_new;
            if (pop_op.emit)
            begin
                code_shift_next       = msd_pkg::CODE_START;
                overflow_seen_next    = 1'b0;
                res_valid_next        = 1'b1;
                res_next.decoded_char = ovf_new ? msd_pkg::NO_CHAR
                                                : msd_pkg::lookup_code(code_new);
                res_next.message_done = pop_op.eom;
                res_next.overlong     = ovf_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_shift_reg    <= msd_pkg::CODE_START;
            overflow_seen_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            code_shift_reg    <= code_shift_next;
            overflow_seen_reg <= overflow_seen_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[design/morse_symbol_decoder_top.sv]
// Morse decoder: one text byte a beat, 'i' a dit, 'a' a dah, space or the
// end_of_message flag closes a character and yields one result beat.
// A byte is taken every cycle while the op queue between the classifier and
// the executor has room; a closing byte's op passes a queue entry, then the
// result register. The executor does one op per cycle (shift, lookup or both),
// so the rate is one byte per cycle whenever the result side takes beats.
module morse_symbol_decoder_top #(
    parameter int QUEUE_DEPTH = msd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sym_valid,
    output logic          sym_ready,
    input  msd_pkg::sym_t sym,
    output logic          res_valid,
    input  logic          res_ready,
    output msd_pkg::res_t res
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    msd_pkg::q_status_t q_status;
    msd_pkg::op_t       push_op;
    msd_pkg::op_t       pop_op;
    logic               push;
    logic               pop;
    logic [CNT_W-1:0]   q_count;

    msd_front u_front (
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym),
        .q_status  (q_status),
        .push      (push),
        .push_op   (push_op)
    );

    msd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .pop_op   (pop_op),
        .q_status (q_status),
        .count    (q_count)
    );

    msd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_op    (pop_op),
        .pop       (pop),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("op queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty op queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("push into full op queue");

    a_overlong_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.overlong) |-> (res.decoded_char == msd_pkg::NO_CHAR))
        else $error("overlong result carries a character");

endmodule

[test/morse_symbol_decoder_top_tb.sv]
`timescale 1ns / 1ps

module morse_symbol_decoder_top_tb;

    localparam int BEAT_TARGET = 750;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIRECTED_COUNT = 23;
    localparam msd_pkg::res_t NO_RESULT = '0;

    typedef struct packed {
        msd_pkg::sym_t beat;
        logic          typed;
        msd_pkg::res_t want;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sym_valid = 1'b0;
    logic sym_ready;
    msd_pkg::sym_t sym = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    msd_pkg::res_t res;

    logic row_typed = 1'b0;
    msd_pkg::res_t row_want = '0;
    logic steady = 1'b0;

    logic [7:0] code_reg = msd_pkg::CODE_START;
    logic code_overrun = 1'b0;
    msd_pkg::res_t predicted;
    msd_pkg::res_t expected_chars [$];
    int fail_count = 0;
    int beats_sent = 0;
    int cycle_count = 0;

    directed_row_t directed_rows [DIRECTED_COUNT] = '{
        {msd_pkg::GAP_BYTE, 1'b0, 1'b1, msd_pkg::NO_CHAR, 1'b0, 1'b0},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::GAP_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::GAP_BYTE, 1'b0, 1'b1, 8'h20, 1'b0, 1'b0},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DAH_BYTE, 1'b0, 1'b0, NO_RESULT},
        {8'hFF, 1'b1, 1'b1, msd_pkg::NO_CHAR, 1'b1, 1'b1},
        {8'h00, 1'b0, 1'b0, NO_RESULT},
        {msd_pkg::DIT_BYTE, 1'b1, 1'b1, 8'h65, 1'b1, 1'b0}
    };

    morse_symbol_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_valid (sym_valid),
        .sym_ready (sym_ready),
        .sym       (sym),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] morse_char(input logic [7:0] code);
        case (code)
            8'h06: return "a";   8'h17: return "b";   8'h15: return "c";
            8'h0B: return "d";   8'h03: return "e";   8'h1D: return "f";
            8'h09: return "g";   8'h1F: return "h";   8'h07: return "i";
            8'h18: return "j";   8'h0A: return "k";   8'h1B: return "l";
            8'h04: return "m";   8'h05: return "n";   8'h08: return "o";
            8'h19: return "p";   8'h12: return "q";   8'h0D: return "r";
            8'h0F: return "s";   8'h02: return "t";   8'h0E: return "u";
            8'h1E: return "v";   8'h0C: return "w";   8'h16: return "x";
            8'h14: return "y";   8'h13: return "z";
            8'h30: return "1";   8'h38: return "2";   8'h3C: return "3";
            8'h3E: return "4";   8'h3F: return "5";   8'h2F: return "6";
            8'h27: return "7";   8'h23: return "8";   8'h21: return "9";
            8'h20: return "0";
            8'h6A: return ".";   8'h73: return "?";   8'h54: return "!";
            8'h29: return "(";   8'h53: return ")";   8'h47: return ":";
            8'h2E: return "=";   8'h5E: return "-";   8'h6D: return "\"";
            8'h4C: return ",";   8'h61: return "'";   8'h2D: return "/";
            8'h55: return ";";   8'h72: return "_";   8'h65: return "@";
            8'hFF: return " ";
            default: return msd_pkg::NO_CHAR;
        endcase
    endfunction

    function automatic logic decode_step(input msd_pkg::sym_t b, output msd_pkg::res_t r);
        r = '0;
        if (b.symbol_byte == msd_pkg::DIT_BYTE || b.symbol_byte == msd_pkg::DAH_BYTE)
        begin
            if (code_reg[7])
                code_overrun = 1'b1;
            code_reg = {code_reg[6:0], b.symbol_byte == msd_pkg::DIT_BYTE};
        end
        if (b.symbol_byte == msd_pkg::GAP_BYTE || b.end_of_message)
        begin
            r.decoded_char = code_overrun ? msd_pkg::NO_CHAR : morse_char(code_reg);
            r.message_done = b.end_of_message;
            r.overlong = code_overrun;
            code_reg = msd_pkg::CODE_START;
            code_overrun = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic compare_char(input msd_pkg::res_t want, input msd_pkg::res_t got);
        logic bad;
        bad = 1'b0;
        if (got.decoded_char !== want.decoded_char)
        begin
            $display("%0t: decoded_char expected %h got %h", $time,
                     want.decoded_char, got.decoded_char);
            bad = 1'b1;
        end
        if (got.message_done !== want.message_done)
        begin
            $display("%0t: message_done expected %b got %b", $time,
                     want.message_done, got.message_done);
            bad = 1'b1;
        end
        if (got.overlong !== want.overlong)
        begin
            $display("%0t: overlong expected %b got %b", $time,
                     want.overlong, got.overlong);
            bad = 1'b1;
        end
        if (bad)
            fail_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sym_valid && sym_ready)
            begin
                if (decode_step(sym, predicted))
                    expected_chars.push_back(row_typed ? row_want : predicted);
            end
            if (res_valid && res_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $display("%0t: result %h with nothing expected", $time, res);
                    fail_count++;
                end
                else
                    compare_char(expected_chars.pop_front(), res);
            end
        end
    end

    always @(negedge clk)
        res_ready <= steady || ($urandom_range(0, 99) >= 13);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Some tests failed");
        $finish;
    end

    task automatic send_beat(input msd_pkg::sym_t b, input logic typed,
                             input msd_pkg::res_t want);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            sym_valid <= 1'b0;
            @(negedge clk);
        end
        sym_valid <= 1'b1;
        sym <= b;
        row_typed <= typed;
        row_want <= want;
        // hold the beat until taken
        do
            @(posedge clk);
        while (!sym_ready);
        beats_sent++;
    endtask

    task automatic drain_chars();
        @(negedge clk);
        sym_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int n;
        int kind;
        logic eom_on;
        logic eom_on_last;
        logic drained;
        msd_pkg::sym_t b;

        drained = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
        drain_chars();

        while (beats_sent < BEAT_TARGET + DIRECTED_COUNT)
        begin
            steady = (beats_sent >= 300 && beats_sent < 420);
            if (!drained && beats_sent >= 500)
            begin
                drain_chars();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 85)
            begin
                if (kind < 70)
                    n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 7);
                else
                    n = $urandom_range(8, 11);
                eom_on = $urandom_range(0, 99) < 15;
                eom_on_last = eom_on && n > 0 && $urandom_range(0, 1);
                for (int k = 0; k < n; k++)
                begin
                    b.symbol_byte = $urandom_range(0, 1) ? msd_pkg::DIT_BYTE
                                                         : msd_pkg::DAH_BYTE;
                    b.end_of_message = (k == n - 1) && eom_on_last;
                    send_beat(b, 1'b0, NO_RESULT);
                    if ($urandom_range(0, 99) < 8)
                        send_beat({8'($urandom_range(0, 255)), 1'b0}, 1'b0, NO_RESULT);
                end
                if (!eom_on_last)
                begin
                    b.symbol_byte = (eom_on && $urandom_range(0, 1)) ?
                                    8'($urandom_range(0, 255)) : msd_pkg::GAP_BYTE;
                    b.end_of_message = eom_on;
                    send_beat(b, 1'b0, NO_RESULT);
                end
            end
            else
                send_beat({8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0},
                          1'b0, NO_RESULT);
        end
        steady = 1'b0;

        drain_chars();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
